/* rtl/rgmd_pkg.sv */
`timescale 1ns / 1ps
package rgmd_pkg;

  // Fixed field widths of the item and result channels.
  localparam int KIND_W     = 1;
  localparam int CODE_W     = 8;
  localparam int BYTE_W     = 8;
  localparam int SCALE_W    = 4;
  localparam int ROW_IDX_W  = 6;
  localparam int ROW_BITS_W = 64;
  localparam int SIZE_W     = 7;
  localparam int ADV_W      = 12;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_START = 1'b0;
  localparam logic [KIND_W-1:0] KIND_RUN   = 1'b1;

  // Run byte codes and limits.
  localparam logic [BYTE_W-1:0]  RUN_NEW_ROW     = 8'd254;
  localparam logic [BYTE_W-1:0]  RUN_END         = 8'd255;
  localparam logic [CODE_W-1:0]  CODE_LAST_VALID = 8'd127;
  localparam logic [SCALE_W-1:0] SCALE_RESET     = 4'd1;

  // Readout sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } rgmd_state_t;

  // Events raised by the pen unit when an item is accepted.
  typedef struct packed {
    logic fail;
    logic empty;
    logic done;
  } rgmd_evt_t;

endpackage

/* rtl/rgmd_if.sv */
`timescale 1ns / 1ps

// Input item channel.
interface rgmd_item_if;
  logic                          valid;
  logic                          ready;
  logic [rgmd_pkg::KIND_W-1:0]   kind;
  logic [rgmd_pkg::CODE_W-1:0]   char_code;
  logic                          glyph_present;
  logic [rgmd_pkg::BYTE_W-1:0]   glyph_width;
  logic [rgmd_pkg::BYTE_W-1:0]   run_byte;

  modport source (output valid, kind, char_code, glyph_present, glyph_width, run_byte,
                  input ready);
  modport sink (input valid, kind, char_code, glyph_present, glyph_width, run_byte,
                output ready);
endinterface

// Result channel.
interface rgmd_result_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic [rgmd_pkg::ROW_IDX_W-1:0]    row_index;
  logic [rgmd_pkg::ROW_BITS_W-1:0]   row_bits;
  logic [rgmd_pkg::SIZE_W-1:0]       width;
  logic [rgmd_pkg::SIZE_W-1:0]       height;
  logic [rgmd_pkg::ADV_W-1:0]        advance;
  logic                              last;

  modport source (output valid, ok, row_index, row_bits, width, height, advance, last,
                  input ready);
  modport sink (input valid, ok, row_index, row_bits, width, height, advance, last,
                output ready);
endinterface

// Configuration write channel for the scale register.
interface rgmd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rgmd_pkg::SCALE_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/rgmd_mask_ram.sv */
`timescale 1ns / 1ps
module rgmd_mask_ram #(
  parameter int GLYPH_DIM = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic                         we,
  input  logic [$clog2(GLYPH_DIM)-1:0] waddr,
  input  logic [GLYPH_DIM-1:0]         wdata,
  input  logic [$clog2(GLYPH_DIM)-1:0] raddr,
  output logic [GLYPH_DIM-1:0]         rdata
);

  logic [GLYPH_DIM-1:0] mem [GLYPH_DIM];
  logic [GLYPH_DIM-1:0] row_valid;
  logic [GLYPH_DIM-1:0] rd_word;
  logic                 rd_valid;

  // Row storage: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_word <= mem[raddr];
  end

  // Per-row valid bits: a row never written since the last start reads as zero.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_valid <= '0;
    end else if (we) begin
      row_valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= row_valid[raddr];
    end
  end

  assign rdata = rd_valid ? rd_word : '0;

endmodule

/* rtl/rgmd_pen.sv */
`timescale 1ns / 1ps
module rgmd_pen #(
  parameter int GLYPH_DIM = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [rgmd_pkg::KIND_W-1:0]        kind,
  input  logic [rgmd_pkg::CODE_W-1:0]        char_code,
  input  logic                               glyph_present,
  input  logic [rgmd_pkg::BYTE_W-1:0]        glyph_width,
  input  logic [rgmd_pkg::BYTE_W-1:0]        run_byte,
  input  logic [rgmd_pkg::SCALE_W-1:0]       scale,
  output rgmd_pkg::rgmd_evt_t                evt,
  output logic [rgmd_pkg::SIZE_W-1:0]        box_width,
  output logic [rgmd_pkg::SIZE_W-1:0]        box_height,
  output logic [rgmd_pkg::ADV_W-1:0]         advance,
  output logic                               mem_clear,
  output logic                               mem_we,
  output logic [$clog2(GLYPH_DIM)-1:0]       mem_waddr,
  output logic [GLYPH_DIM-1:0]               mem_wdata
);

  localparam int PEN_W = $clog2(GLYPH_DIM + 1);
  localparam int AW    = $clog2(GLYPH_DIM);
  localparam int SUM_W = ((PEN_W > rgmd_pkg::BYTE_W) ? PEN_W : rgmd_pkg::BYTE_W) + 1;
  localparam logic [PEN_W-1:0] PEN_MAX = PEN_W'(GLYPH_DIM);
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(GLYPH_DIM);

  logic [PEN_W-1:0]     pen_col;
  logic [PEN_W-1:0]     pen_row;
  logic [AW-1:0]        ink_max_col;
  logic [AW-1:0]        ink_max_row;
  logic                 ink_seen;
  logic                 glyph_open;
  logic [GLYPH_DIM-1:0] cur_bits;

  logic [SUM_W-1:0]     col_sum;
  logic [PEN_W-1:0]     col_new;
  logic                 ink_hit;
  logic                 row_in_store;
  logic                 is_start;
  logic                 is_run;
  logic                 start_bad;
  logic                 is_row_end;

  // Pen advance with saturation at the store edge.
  assign col_sum      = SUM_W'(pen_col) + SUM_W'(run_byte);
  assign col_new      = (col_sum > SUM_MAX) ? PEN_MAX : col_sum[PEN_W-1:0];
  assign row_in_store = (pen_row < PEN_MAX);
  assign ink_hit      = (col_new < PEN_MAX) && row_in_store;

  // Item decode.
  assign is_start   = accept && (kind == rgmd_pkg::KIND_START);
  assign is_run     = accept && (kind == rgmd_pkg::KIND_RUN) && glyph_open;
  assign start_bad  = (char_code > rgmd_pkg::CODE_LAST_VALID) || !glyph_present ||
                      (scale == '0);
  assign is_row_end = (run_byte == rgmd_pkg::RUN_NEW_ROW) ||
                      (run_byte == rgmd_pkg::RUN_END);

  assign evt.fail  = is_start && start_bad;
  assign evt.empty = is_run && (run_byte == rgmd_pkg::RUN_END) && !ink_seen;
  assign evt.done  = is_run && (run_byte == rgmd_pkg::RUN_END) && ink_seen;

  // The current row is built in a register and stored when the pen leaves it.
  assign mem_clear = is_start;
  assign mem_we    = is_run && is_row_end && row_in_store;
  assign mem_waddr = pen_row[AW-1:0];
  assign mem_wdata = cur_bits;

  assign box_width  = rgmd_pkg::SIZE_W'(ink_max_col) + rgmd_pkg::SIZE_W'(1);
  assign box_height = rgmd_pkg::SIZE_W'(ink_max_row) + rgmd_pkg::SIZE_W'(1);

  // Pen, ink box and glyph state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_col     <= '0;
      pen_row     <= '0;
      ink_max_col <= '0;
      ink_max_row <= '0;
      ink_seen    <= 1'b0;
      glyph_open  <= 1'b0;
      advance     <= '0;
      cur_bits    <= '0;
    end else if (is_start) begin
      pen_col     <= '0;
      pen_row     <= '0;
      ink_max_col <= '0;
      ink_max_row <= '0;
      ink_seen    <= 1'b0;
      cur_bits    <= '0;
      glyph_open  <= !start_bad;
      advance     <= start_bad ? '0 :
                     rgmd_pkg::ADV_W'(glyph_width) * rgmd_pkg::ADV_W'(scale);
    end else if (is_run) begin
      case (run_byte)
        rgmd_pkg::RUN_NEW_ROW: begin
          if (row_in_store) begin
            pen_row <= pen_row + PEN_W'(1);
          end
          pen_col  <= '0;
          cur_bits <= '0;
        end
        rgmd_pkg::RUN_END: begin
          glyph_open <= 1'b0;
        end
        default: begin
          pen_col <= col_new;
          if (ink_hit) begin
            cur_bits[col_new[AW-1:0]] <= 1'b1;
            if (!ink_seen || (col_new[AW-1:0] > ink_max_col)) begin
              ink_max_col <= col_new[AW-1:0];
            end
            if (!ink_seen || (pen_row[AW-1:0] > ink_max_row)) begin
              ink_max_row <= pen_row[AW-1:0];
            end
            ink_seen <= 1'b1;
          end
        end
      endcase
    end
  end

endmodule

/* rtl/rle_glyph_mask_decoder.sv */
`timescale 1ns / 1ps
// Start and run items are taken one per cycle while idle with the output register free;
// each finishes in the cycle it is accepted. A failed start or an empty glyph gives its
// result in the cycle after acceptance. After the end byte of an inked glyph each row is
// read from the registered mask store, then loaded into the output register when free.
// Reset is synchronous: pen, ink box, row valid bits and result valid clear, scale returns to 1.
module rle_glyph_mask_decoder #(
  parameter int GLYPH_DIM = 64
) (
  input  logic               clk,
  input  logic               rst,
  rgmd_item_if.sink          items,
  rgmd_result_if.source      results,
  rgmd_cfg_if.sink           cfg
);

  localparam int AW = $clog2(GLYPH_DIM);

  rgmd_pkg::rgmd_state_t             state;
  rgmd_pkg::rgmd_state_t             state_next;
  rgmd_pkg::rgmd_evt_t               evt;

  logic [rgmd_pkg::SCALE_W-1:0]      scale;
  logic                              accept;
  logic                              out_free;
  logic                              load_row;
  logic                              row_last;
  logic [AW-1:0]                     row_cnt;

  logic [rgmd_pkg::SIZE_W-1:0]       box_width;
  logic [rgmd_pkg::SIZE_W-1:0]       box_height;
  logic [rgmd_pkg::ADV_W-1:0]        advance;
  logic                              mem_clear;
  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  logic [GLYPH_DIM-1:0]              mem_wdata;
  logic [GLYPH_DIM-1:0]              mem_rdata;
  logic [rgmd_pkg::ROW_BITS_W-1:0]   col_mask;

  logic                              out_valid;
  logic                              out_ok;
  logic [rgmd_pkg::ROW_IDX_W-1:0]    out_row;
  logic [rgmd_pkg::ROW_BITS_W-1:0]   out_bits;
  logic [rgmd_pkg::SIZE_W-1:0]       out_width;
  logic [rgmd_pkg::SIZE_W-1:0]       out_height;
  logic [rgmd_pkg::ADV_W-1:0]        out_adv;
  logic                              out_last;

  // Scale register, always writable.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= rgmd_pkg::SCALE_RESET;
    end else if (cfg.valid) begin
      scale <= cfg.data;
    end
  end

  // Items are taken while no readout runs and the output register can take a result.
  assign out_free    = !out_valid || results.ready;
  assign items.ready = (state == rgmd_pkg::ST_IDLE) && out_free;
  assign accept      = items.valid && items.ready;

  rgmd_pen #(
    .GLYPH_DIM (GLYPH_DIM)
  ) u_pen (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .kind          (items.kind),
    .char_code     (items.char_code),
    .glyph_present (items.glyph_present),
    .glyph_width   (items.glyph_width),
    .run_byte      (items.run_byte),
    .scale         (scale),
    .evt           (evt),
    .box_width     (box_width),
    .box_height    (box_height),
    .advance       (advance),
    .mem_clear     (mem_clear),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata)
  );

  rgmd_mask_ram #(
    .GLYPH_DIM (GLYPH_DIM)
  ) u_mask_ram (
    .clk   (clk),
    .rst   (rst),
    .clear (mem_clear),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (row_cnt),
    .rdata (mem_rdata)
  );

  // Readout sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rgmd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign row_last = ((rgmd_pkg::SIZE_W'(row_cnt) + rgmd_pkg::SIZE_W'(1)) == box_height);
  assign load_row = (state == rgmd_pkg::ST_LOAD) && out_free;

  // Next state: read a row, then load it into the output register.
  always_comb begin
    state_next = state;
    case (state)
      rgmd_pkg::ST_IDLE: begin
        if (evt.done) begin
          state_next = rgmd_pkg::ST_READ;
        end
      end
      rgmd_pkg::ST_READ: begin
        state_next = rgmd_pkg::ST_LOAD;
      end
      rgmd_pkg::ST_LOAD: begin
        if (out_free) begin
          state_next = row_last ? rgmd_pkg::ST_IDLE : rgmd_pkg::ST_READ;
        end
      end
      default: begin
        state_next = rgmd_pkg::ST_IDLE;
      end
    endcase
  end

  // Row counter for the readout.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
    end else if (evt.done) begin
      row_cnt <= '0;
    end else if (load_row && !row_last) begin
      row_cnt <= row_cnt + AW'(1);
    end
  end

  // Keep only the columns inside the ink box.
  always_comb begin
    for (int i = 0; i < rgmd_pkg::ROW_BITS_W; i++) begin
      col_mask[i] = (rgmd_pkg::SIZE_W'(i) < box_width);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (evt.fail || evt.empty || load_row) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.fail) begin
      out_ok     <= 1'b0;
      out_row    <= '0;
      out_bits   <= '0;
      out_width  <= '0;
      out_height <= '0;
      out_adv    <= '0;
      out_last   <= 1'b1;
    end else if (evt.empty) begin
      out_ok     <= 1'b1;
      out_row    <= '0;
      out_bits   <= '0;
      out_width  <= '0;
      out_height <= '0;
      out_adv    <= advance;
      out_last   <= 1'b1;
    end else if (load_row) begin
      out_ok     <= 1'b1;
      out_row    <= rgmd_pkg::ROW_IDX_W'(row_cnt);
      out_bits   <= rgmd_pkg::ROW_BITS_W'(mem_rdata) & col_mask;
      out_width  <= box_width;
      out_height <= box_height;
      out_adv    <= advance;
      out_last   <= row_last;
    end
  end

  assign results.valid     = out_valid;
  assign results.ok        = out_ok;
  assign results.row_index = out_row;
  assign results.row_bits  = out_bits;
  assign results.width     = out_width;
  assign results.height    = out_height;
  assign results.advance   = out_adv;
  assign results.last      = out_last;

  // A row that is not the final one is only ever shown during a readout.
  a_mid_row_in_readout: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (state != rgmd_pkg::ST_IDLE))
    else $error("non-final row shown outside a readout");

  // The readout never runs past the ink box height.
  a_row_in_box: assert property (@(posedge clk) disable iff (rst)
    (state == rgmd_pkg::ST_LOAD) |-> (rgmd_pkg::SIZE_W'(row_cnt) < box_height))
    else $error("readout row beyond ink box");

  // Loading the final row returns the sequencer to idle.
  a_last_ends_readout: assert property (@(posedge clk) disable iff (rst)
    (load_row && row_last) |=> (state == rgmd_pkg::ST_IDLE))
    else $error("readout did not end after the final row");

  // The mask store is never written or cleared during a readout.
  a_store_quiet: assert property (@(posedge clk) disable iff (rst)
    (state != rgmd_pkg::ST_IDLE) |-> (!mem_we && !mem_clear))
    else $error("mask store touched during readout");

endmodule

/* bench/rle_glyph_mask_decoder_test.sv */
`timescale 1ns / 1ps
module rle_glyph_mask_decoder_test;

  localparam int GLYPH_DIM = 64;

  // One item as offered on the item channel.
  typedef struct packed {
    logic [rgmd_pkg::KIND_W-1:0] kind;
    logic [rgmd_pkg::CODE_W-1:0] char_code;
    logic                        glyph_present;
    logic [rgmd_pkg::BYTE_W-1:0] glyph_width;
    logic [rgmd_pkg::BYTE_W-1:0] run_byte;
  } glyph_item_t;

  // One row result of a decoded glyph.
  typedef struct packed {
    logic                            ok;
    logic [rgmd_pkg::ROW_IDX_W-1:0]  row_index;
    logic [rgmd_pkg::ROW_BITS_W-1:0] row_bits;
    logic [rgmd_pkg::SIZE_W-1:0]     width;
    logic [rgmd_pkg::SIZE_W-1:0]     height;
    logic [rgmd_pkg::ADV_W-1:0]      advance;
    logic                            last;
  } glyph_row_t;

  // Keeps its own copy of the mask store and pen, and the rows still owed by the block.
  class glyph_scoreboard;
    bit [63:0] ink_rows [64];
    int unsigned pen_col, pen_row, ink_max_col, ink_max_row;
    bit ink_seen, glyph_open;
    logic [rgmd_pkg::ADV_W-1:0] advance_hold;
    logic [rgmd_pkg::SCALE_W-1:0] scale;
    glyph_row_t owed_rows[$];
    int mismatches, rows_checked, failed_starts, empty_glyphs, tallest;

    function new();
      scale = rgmd_pkg::SCALE_RESET;
      advance_hold = '0;
      glyph_open = 1'b0;
      clear_glyph();
    endfunction

    function void clear_glyph();
      foreach (ink_rows[i]) ink_rows[i] = '0;
      pen_col = 0;
      pen_row = 0;
      ink_max_col = 0;
      ink_max_row = 0;
      ink_seen = 1'b0;
    endfunction

    function void set_scale(logic [rgmd_pkg::SCALE_W-1:0] value);
      scale = value;
    endfunction

    function void owe_row(bit ok, int unsigned row, logic [63:0] bits, int unsigned w,
                          int unsigned h, bit last);
      glyph_row_t r;
      r.ok = ok;
      r.row_index = row[rgmd_pkg::ROW_IDX_W-1:0];
      r.row_bits = bits;
      r.width = w[rgmd_pkg::SIZE_W-1:0];
      r.height = h[rgmd_pkg::SIZE_W-1:0];
      r.advance = advance_hold;
      r.last = last;
      owed_rows.push_back(r);
    endfunction

    // Applies one accepted item; returns 0 when the block simply ignores it.
    function bit note_item(glyph_item_t it);
      int unsigned w, h, prod;
      logic [63:0] keep;
      if (it.kind == rgmd_pkg::KIND_START) begin
        clear_glyph();
        glyph_open = 1'b0;
        advance_hold = '0;
        if (it.char_code > rgmd_pkg::CODE_LAST_VALID || !it.glyph_present || scale == 0)
        begin
          owe_row(1'b0, 0, '0, 0, 0, 1'b1);
          failed_starts++;
        end else begin
          prod = it.glyph_width * scale;
          advance_hold = prod[rgmd_pkg::ADV_W-1:0];
          glyph_open = 1'b1;
        end
        return 1'b1;
      end
      if (!glyph_open) return 1'b0;
      if (it.run_byte == rgmd_pkg::RUN_NEW_ROW) begin
        if (pen_row < GLYPH_DIM) pen_row++;
        pen_col = 0;
        return 1'b1;
      end
      if (it.run_byte == rgmd_pkg::RUN_END) begin
        glyph_open = 1'b0;
        if (!ink_seen) begin
          owe_row(1'b1, 0, '0, 0, 0, 1'b1);
          empty_glyphs++;
        end else begin
          w = ink_max_col + 1;
          h = ink_max_row + 1;
          keep = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
          for (int unsigned y = 0; y < h; y++)
            owe_row(1'b1, y, ink_rows[y] & keep, w, h, y + 1 == h);
          if (h > tallest) tallest = h;
        end
        return 1'b1;
      end
      // Skip and paint: the pen saturates at the store edge, where ink is lost.
      pen_col += it.run_byte;
      if (pen_col > GLYPH_DIM) pen_col = GLYPH_DIM;
      if (pen_col < GLYPH_DIM && pen_row < GLYPH_DIM) begin
        ink_rows[pen_row][pen_col] = 1'b1;
        if (!ink_seen || pen_col > ink_max_col) ink_max_col = pen_col;
        if (!ink_seen || pen_row > ink_max_row) ink_max_row = pen_row;
        ink_seen = 1'b1;
      end
      return 1'b1;
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("[%0t] MISMATCH %s", $realtime, msg);
      mismatches++;
    endtask

    task check_row(glyph_row_t got);
      glyph_row_t want;
      if (owed_rows.size() == 0) begin
        report($sformatf("result row %0d arrived with nothing expected", got.row_index));
        return;
      end
      want = owed_rows.pop_front();
      rows_checked++;
      if (got.ok !== want.ok)
        report($sformatf("ok: got %0h, expected %0h", got.ok, want.ok));
      if (got.row_index !== want.row_index)
        report($sformatf("row_index: got %0d, expected %0d", got.row_index, want.row_index));
      if (got.row_bits !== want.row_bits)
        report($sformatf("row_bits of row %0d: got %h, expected %h", want.row_index,
                         got.row_bits, want.row_bits));
      if (got.width !== want.width)
        report($sformatf("width: got %0d, expected %0d", got.width, want.width));
      if (got.height !== want.height)
        report($sformatf("height: got %0d, expected %0d", got.height, want.height));
      if (got.advance !== want.advance)
        report($sformatf("advance: got %0d, expected %0d", got.advance, want.advance));
      if (got.last !== want.last)
        report($sformatf("last on row %0d: got %0h, expected %0h", want.row_index,
                         got.last, want.last));
    endtask
  endclass

  logic clk;
  logic rst;

  rgmd_item_if   items_if();
  rgmd_result_if results_if();
  rgmd_cfg_if    cfg_if();

  rle_glyph_mask_decoder #(.GLYPH_DIM(GLYPH_DIM)) dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  glyph_scoreboard sb = new();

  int src_gap_pct;
  int sink_stall_pct;
  int stall_left;
  int live_items;
  int ignored_items;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up after a generous fixed time.
  initial begin
    #40ms;
    $display("FAIL rle_glyph_mask_decoder");
    $finish;
  end

  // Result side: ready drops in random bursts while stalls are enabled.
  initial begin
    results_if.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        results_if.ready <= 1'b0;
      end else if (sink_stall_pct > 0 && $urandom_range(99) < sink_stall_pct) begin
        stall_left = $urandom_range(1, 10) - 1;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= 1'b1;
      end
    end
  end

  // Every result transaction is checked against the oldest owed row.
  always @(posedge clk) begin
    glyph_row_t got;
    if (!rst && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
      got.ok = results_if.ok;
      got.row_index = results_if.row_index;
      got.row_bits = results_if.row_bits;
      got.width = results_if.width;
      got.height = results_if.height;
      got.advance = results_if.advance;
      got.last = results_if.last;
      sb.check_row(got);
    end
  end

  function automatic glyph_item_t start_item(int code, bit present, int gw);
    glyph_item_t it;
    it.kind = rgmd_pkg::KIND_START;
    it.char_code = code[rgmd_pkg::CODE_W-1:0];
    it.glyph_present = present;
    it.glyph_width = gw[rgmd_pkg::BYTE_W-1:0];
    it.run_byte = $urandom_range(0, 255);
    return it;
  endfunction

  function automatic glyph_item_t run_item(int b);
    glyph_item_t it;
    it.kind = rgmd_pkg::KIND_RUN;
    it.char_code = $urandom_range(0, 255);
    it.glyph_present = $urandom_range(0, 1);
    it.glyph_width = $urandom_range(0, 255);
    it.run_byte = b[rgmd_pkg::BYTE_W-1:0];
    return it;
  endfunction

  function automatic int pick_run_byte();
    int r;
    r = $urandom_range(99);
    if (r < 20) return rgmd_pkg::RUN_NEW_ROW;
    if (r < 65) return $urandom_range(0, 7);
    if (r < 88) return $urandom_range(8, 63);
    return $urandom_range(64, 253);
  endfunction

  function automatic int valid_code();
    return $urandom_range(0, rgmd_pkg::CODE_LAST_VALID);
  endfunction

  // Offers one item, sometimes after a random idle burst, and waits for its transaction.
  task automatic send_item(glyph_item_t it);
    int gap;
    gap = 0;
    if (src_gap_pct > 0 && $urandom_range(99) < src_gap_pct) gap = $urandom_range(1, 10);
    @(negedge clk);
    if (gap > 0) begin
      items_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    items_if.valid <= 1'b1;
    items_if.kind <= it.kind;
    items_if.char_code <= it.char_code;
    items_if.glyph_present <= it.glyph_present;
    items_if.glyph_width <= it.glyph_width;
    items_if.run_byte <= it.run_byte;
    do @(posedge clk); while (items_if.ready !== 1'b1);
    if (sb.note_item(it)) live_items++;
    else ignored_items++;
  endtask

  task automatic park_items();
    @(negedge clk);
    items_if.valid <= 1'b0;
  endtask

  // Waits until every owed row is in, plus a margin for a start still clearing the store.
  task automatic wait_for_rows();
    while (sb.owed_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_scale(logic [rgmd_pkg::SCALE_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    sb.set_scale(value);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Hand-picked items: failures, empty and clipped glyphs, dropped glyphs.
  task automatic run_directed();
    send_item(run_item(9));
    send_item(start_item(128, 1'b1, 10));
    send_item(start_item(255, 1'b1, 10));
    send_item(start_item(5, 1'b0, 10));
    send_item(run_item(3));
    send_item(start_item(0, 1'b1, 255));
    send_item(run_item(rgmd_pkg::RUN_END));
    send_item(run_item(2));
    send_item(start_item(rgmd_pkg::CODE_LAST_VALID, 1'b1, 0));
    send_item(run_item(0));
    send_item(run_item(rgmd_pkg::RUN_END));
    send_item(start_item(65, 1'b1, 200));
    send_item(run_item(63));
    send_item(run_item(rgmd_pkg::RUN_NEW_ROW));
    send_item(run_item(0));
    send_item(run_item(1));
    send_item(run_item(253));
    send_item(run_item(rgmd_pkg::RUN_END));
    send_item(start_item(66, 1'b1, 7));
    send_item(run_item(5));
    send_item(start_item(67, 1'b1, 8));
    send_item(run_item(2));
    send_item(run_item(rgmd_pkg::RUN_NEW_ROW));
    send_item(run_item(rgmd_pkg::RUN_NEW_ROW));
    send_item(run_item(rgmd_pkg::RUN_END));
  endtask

  // One random glyph: mostly well formed, with tall, wide, failed, dropped and noisy ones.
  task automatic random_glyph();
    int r, n;
    glyph_item_t it;
    r = $urandom_range(99);
    if (r < 70) begin
      send_item(start_item(valid_code(), 1'b1, $urandom_range(0, 255)));
      n = $urandom_range(0, 12);
      repeat (n) send_item(run_item(pick_run_byte()));
      send_item(run_item(rgmd_pkg::RUN_END));
    end else if (r < 74) begin
      // Tall glyph: runs down toward the bottom row, at times past it.
      send_item(start_item(valid_code(), 1'b1, $urandom_range(0, 255)));
      n = $urandom_range(60, 66);
      repeat (n) begin
        if ($urandom_range(0, 1)) send_item(run_item($urandom_range(0, 70)));
        send_item(run_item(rgmd_pkg::RUN_NEW_ROW));
      end
      send_item(run_item($urandom_range(0, 63)));
      send_item(run_item(rgmd_pkg::RUN_END));
    end else if (r < 80) begin
      // Wide glyph: long skips that may reach and pass the right edge.
      send_item(start_item(valid_code(), 1'b1, $urandom_range(0, 255)));
      n = $urandom_range(1, 5);
      repeat (n) begin
        send_item(run_item($urandom_range(20, 253)));
        if ($urandom_range(0, 2) == 0) send_item(run_item(rgmd_pkg::RUN_NEW_ROW));
      end
      send_item(run_item(rgmd_pkg::RUN_END));
    end else if (r < 88) begin
      if ($urandom_range(0, 1))
        send_item(start_item($urandom_range(128, 255), $urandom_range(0, 1),
                             $urandom_range(0, 255)));
      else
        send_item(start_item(valid_code(), 1'b0, $urandom_range(0, 255)));
      n = $urandom_range(0, 3);
      repeat (n) send_item(run_item($urandom_range(0, 255)));
    end else if (r < 94) begin
      // Dropped glyph: the next start arrives before the end byte.
      send_item(start_item(valid_code(), 1'b1, $urandom_range(0, 255)));
      n = $urandom_range(1, 4);
      repeat (n) send_item(run_item(pick_run_byte()));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        it = $urandom_range(0, 1) ? run_item($urandom_range(0, 255))
                                  : start_item($urandom_range(0, 255), $urandom_range(0, 1),
                                               $urandom_range(0, 255));
        send_item(it);
      end
    end
  endtask

  // Stimulus.
  initial begin
    int scales [5];
    int gaps [5];
    int stalls [5];
    int targets [5];
    int phase_base;

    rst = 1'b1;
    items_if.valid = 1'b0;
    items_if.kind = rgmd_pkg::KIND_START;
    items_if.char_code = '0;
    items_if.glyph_present = 1'b0;
    items_if.glyph_width = '0;
    items_if.run_byte = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    src_gap_pct = 25;
    sink_stall_pct = 30;
    live_items = 0;
    ignored_items = 0;

    scales = '{15, 0, $urandom_range(2, 14), 1, $urandom_range(1, 15)};
    gaps = '{25, 10, 40, 15, 0};
    stalls = '{30, 50, 15, 60, 0};
    targets = '{65, 25, 65, 65, 65};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part runs at the reset scale.
    run_directed();
    park_items();
    wait_for_rows();

    // Random phases, each at its own scale and idling mix; the last has no idling.
    for (int p = 0; p < 5; p++) begin
      src_gap_pct = gaps[p];
      sink_stall_pct = stalls[p];
      write_scale(scales[p][rgmd_pkg::SCALE_W-1:0]);
      send_item(start_item(valid_code(), 1'b1, 255));
      send_item(run_item(rgmd_pkg::RUN_END));
      phase_base = live_items;
      while (live_items - phase_base < targets[p]) random_glyph();
      if (sb.glyph_open) send_item(run_item(rgmd_pkg::RUN_END));
      park_items();
      wait_for_rows();
    end

    repeat (40) @(posedge clk);
    $display("Covered %0d live and %0d ignored items over scales 0 to 15.",
             live_items, ignored_items);
    $display("Checked %0d result rows: %0d failed starts, %0d empty glyphs, tallest box %0d.",
             sb.rows_checked, sb.failed_starts, sb.empty_glyphs, sb.tallest);
    if (sb.mismatches == 0 && sb.owed_rows.size() == 0) begin
      $display("PASS rle_glyph_mask_decoder");
    end else begin
      $display("FAIL rle_glyph_mask_decoder");
    end
    $finish;
  end

endmodule
